>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of the checksum block.
// Depends on nothing; the using scope provides clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TCPCS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("tcpcs assertion failed");

// Clocked assertion that is checked during reset as well.
`define TCPCS_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("tcpcs reset assertion failed");

`endif

>>> rtl/core/tcpcs_pkg.sv
// Shared constants and types of the TCP checksum block.
// No dependencies; used by the interfaces, all core modules and the checker.
package tcpcs_pkg;

	localparam int HALF_W   = 16;
	localparam int ADDR_W   = 32;
	localparam int PROTO_W  = 8;
	localparam int SUM_W    = 32;
	// Six pseudo header terms of at most 16 bits each fit in 19 bits.
	localparam int PSEUDO_W = 19;

	localparam logic [HALF_W-1:0] PAD_MASK = 16'hff00;

	// Action codes carried on the input word.
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_WORD  = 1'b1;

	// Classified word held in the queue between front and back.
	typedef struct packed {
		logic                is_start;
		logic                last;
		logic [PSEUDO_W-1:0] value;
	} tcpcs_entry_t;

	// Head of the queue as seen by the back end.
	typedef struct packed {
		logic         valid;
		tcpcs_entry_t entry;
	} tcpcs_head_t;

endpackage

>>> rtl/core/tcpcs_if.sv
// Valid/ready channel interfaces of the TCP checksum block.
// Depends on tcpcs_pkg for the field widths.
interface tcpcs_seg_if;
	import tcpcs_pkg::*;

	logic                valid;
	logic                ready;
	logic                action;
	logic [ADDR_W-1:0]   src_addr;
	logic [ADDR_W-1:0]   dst_addr;
	logic [PROTO_W-1:0]  protocol;
	logic [HALF_W-1:0]   seg_length;
	logic [HALF_W-1:0]   data_word;
	logic                single_byte;
	logic                last;

	modport source (output valid, action, src_addr, dst_addr, protocol, seg_length,
		data_word, single_byte, last, input ready);
	modport sink (input valid, action, src_addr, dst_addr, protocol, seg_length,
		data_word, single_byte, last, output ready);
endinterface

interface tcpcs_csum_if;
	import tcpcs_pkg::*;

	logic              valid;
	logic              ready;
	logic [HALF_W-1:0] checksum;

	modport source (output valid, checksum, input ready);
	modport sink (input valid, checksum, output ready);
endinterface

>>> rtl/core/tcpcs_front.sv
// Front end: accepts input words and reduces each to one queue entry.
// Depends on tcpcs_pkg and tcpcs_seg_if.
module tcpcs_front (
	tcpcs_seg_if.sink             seg,
	input  logic                  q_full,
	output logic                  push,
	output tcpcs_pkg::tcpcs_entry_t push_entry
);
	import tcpcs_pkg::*;

	logic [PSEUDO_W-1:0] pseudo;
	logic [HALF_W-1:0]   word;
	logic                is_start;

	// Pseudo header sum: address halves, protocol and segment length.
	always_comb begin
		pseudo = (PSEUDO_W'(seg.src_addr[ADDR_W-1:HALF_W]) +
			PSEUDO_W'(seg.src_addr[HALF_W-1:0])) +
			(PSEUDO_W'(seg.dst_addr[ADDR_W-1:HALF_W]) +
			PSEUDO_W'(seg.dst_addr[HALF_W-1:0])) +
			(PSEUDO_W'(seg.protocol) + PSEUDO_W'(seg.seg_length));
	end

	// A lone trailing byte is padded with zero in its low half.
	always_comb begin
		word = seg.single_byte ? (seg.data_word & PAD_MASK) : seg.data_word;
	end

	// Classify the word and hand it to the queue while there is room.
	always_comb begin
		is_start            = (seg.action == ACT_START);
		push_entry.is_start = is_start;
		push_entry.last     = seg.last;
		push_entry.value    = is_start ? pseudo : PSEUDO_W'(word);
		seg.ready           = !q_full;
		push                = seg.valid && !q_full;
	end

endmodule

>>> rtl/core/tcpcs_queue.sv
// Short queue that decouples the front end from the accumulator.
// Depends on tcpcs_pkg for the entry type.
module tcpcs_queue #(
	parameter int DEPTH = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  tcpcs_pkg::tcpcs_entry_t push_entry,
	output logic                    full,
	input  logic                    pop,
	output tcpcs_pkg::tcpcs_head_t  head
);
	import tcpcs_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tcpcs_entry_t     entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// Status toward both sides.
	always_comb begin
		full       = (count_q == CNT_W'(DEPTH));
		head.valid = (count_q != '0);
		head.entry = entry_q[rd_ptr_q];
	end

	// Entry storage needs no reset.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_entry;
		end
	end

	// Pointers wrap at the depth, which need not be a power of two.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

endmodule

>>> rtl/core/tcpcs_back.sv
// Back end: running sum, end-of-segment fold and output register.
// Depends on tcpcs_pkg and tcpcs_csum_if.
module tcpcs_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tcpcs_pkg::tcpcs_head_t head,
	output logic                   pop,
	tcpcs_csum_if.source           csum
);
	import tcpcs_pkg::*;

	logic [SUM_W-1:0]  acc_q;
	logic [SUM_W-1:0]  add_sum;
	logic              fin_valid_s1;
	logic [SUM_W-1:0]  fin_sum_s1;
	logic              out_valid_q;
	logic [HALF_W-1:0] checksum_q;
	logic              out_free;
	logic              fin_free;
	logic              fin_load;
	logic [HALF_W:0]   fold1;
	logic [HALF_W:0]   fold2;

	// Pipeline flow: only a last word needs room downstream.
	always_comb begin
		out_free = !out_valid_q || csum.ready;
		fin_free = !fin_valid_s1 || out_free;
		pop      = head.valid &&
			(head.entry.is_start || !head.entry.last || fin_free);
		fin_load = pop && !head.entry.is_start && head.entry.last;
		add_sum  = acc_q + SUM_W'(head.entry.value);
	end

	// Running sum: load on start, add on words, clear after the last word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (pop) begin
			if (head.entry.is_start) begin
				acc_q <= SUM_W'(head.entry.value);
			end else if (head.entry.last) begin
				acc_q <= '0;
			end else begin
				acc_q <= add_sum;
			end
		end
	end

	// Final sum stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s1 <= 1'b0;
		end else if (fin_free) begin
			fin_valid_s1 <= fin_load;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_free && fin_load) begin
			fin_sum_s1 <= add_sum;
		end
	end

	// Fold the carries twice; the second fold cannot carry again.
	always_comb begin
		fold1 = {1'b0, fin_sum_s1[HALF_W-1:0]} + {1'b0, fin_sum_s1[SUM_W-1:HALF_W]};
		fold2 = {1'b0, fold1[HALF_W-1:0]} + (HALF_W + 1)'(fold1[HALF_W]);
	end

	// Output register holds the inverted checksum until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fin_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && fin_valid_s1) begin
			checksum_q <= ~fold2[HALF_W-1:0];
		end
	end

	always_comb begin
		csum.valid    = out_valid_q;
		csum.checksum = checksum_q;
	end

endmodule

>>> rtl/core/tcp_checksum_pseudo_header.sv
// Top level of the TCP checksum with IPv4 pseudo header.
// Depends on tcpcs_pkg, tcpcs_if, tcpcs_front, tcpcs_queue and tcpcs_back.
//
//  Channel  Dir  Handshake    Word contents
//  seg      in   valid/ready  action, addresses, protocol, length, data word, flags
//  csum     out  valid/ready  checksum of one segment, after its last word
//
// One word is taken per cycle while the queue has room; the single 32-bit add of the
// running sum sets that rate. A checksum passes the queue, the final sum stage and the
// output register after the edge that takes its last word.
// While the receiver stalls, two checksums wait in the back end; a further last word
// then waits at the queue head, and input stops once the QUEUE_DEPTH words fill the queue.
// Reset clears the running sum, the queue and both output stages.
module tcp_checksum_pseudo_header #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	tcpcs_seg_if.sink    seg,
	tcpcs_csum_if.source csum
);
	import tcpcs_pkg::*;

	tcpcs_entry_t push_entry;
	tcpcs_head_t  head;
	logic         push;
	logic         pop;
	logic         q_full;

	// Classify incoming words.
	tcpcs_front u_front (
		.seg        (seg),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// Decoupling queue.
	tcpcs_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head       (head)
	);

	// Accumulate and emit.
	tcpcs_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.csum   (csum)
	);

endmodule

>>> rtl/core/tcpcs_checker.sv
// Port-level checks on the TCP checksum block, bound to its top level.
// Depends on tcpcs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tcpcs_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      seg_valid,
	input logic                      seg_ready,
	input logic                      seg_action,
	input logic                      seg_last,
	input logic                      csum_valid,
	input logic                      csum_ready,
	input logic [tcpcs_pkg::HALF_W-1:0] csum_checksum
);
	import tcpcs_pkg::*;

	logic [7:0] pend_q;
	logic       end_in;
	logic       res_out;

	// Count segments that have ended but whose checksum is not yet taken.
	always_comb begin
		end_in  = seg_valid && seg_ready && (seg_action == ACT_WORD) && seg_last;
		res_out = csum_valid && csum_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(end_in) - 8'(res_out);
		end
	end

	`TCPCS_ASSERT(a_valid_hold, csum_valid && !csum_ready |=> csum_valid)
	`TCPCS_ASSERT(a_data_hold, csum_valid && !csum_ready |=> $stable(csum_checksum))
	`TCPCS_ASSERT(a_no_spurious, csum_valid |-> pend_q != 8'd0)
	`TCPCS_ASSERT_RST(a_reset_idle, !arst_n |-> !csum_valid)

endmodule

bind tcp_checksum_pseudo_header tcpcs_checker u_tcpcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.seg_valid     (seg.valid),
	.seg_ready     (seg.ready),
	.seg_action    (seg.action),
	.seg_last      (seg.last),
	.csum_valid    (csum.valid),
	.csum_ready    (csum.ready),
	.csum_checksum (csum.checksum)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Testbench for the TCP checksum block with the IPv4 pseudo header.
// Depends on tcpcs_pkg, the tcpcs interfaces and the tcp_checksum_pseudo_header RTL.
module testbench;
	import tcpcs_pkg::*;

	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;
	localparam int PHASE_WORDS  = 296;

	// One word on the segment channel, with an optional hand-typed checksum.
	typedef struct {
		logic               action;
		logic [ADDR_W-1:0]  src;
		logic [ADDR_W-1:0]  dst;
		logic [PROTO_W-1:0] proto;
		logic [HALF_W-1:0]  seglen;
		logic [HALF_W-1:0]  data;
		logic               single;
		logic               last;
		bit                 typed;
		logic [HALF_W-1:0]  typed_sum;
	} seg_word_t;

	logic clk;
	logic arst_n;

	tcpcs_seg_if  seg ();
	tcpcs_csum_if csum ();

	tcp_checksum_pseudo_header dut (
		.clk    (clk),
		.arst_n (arst_n),
		.seg    (seg),
		.csum   (csum)
	);

	logic [SUM_W-1:0]  seg_sum;
	logic [HALF_W-1:0] checksum_expected[$];
	logic [HALF_W-1:0] want_sum;
	seg_word_t         directed_words[$];
	int                src_idle_pct;
	int                sink_stall_pct;
	int                hold_requests;
	int                hold_served;
	int                hold_left;
	int                words_sent;
	int                errors;

	// Clock with a 2 ns period.
	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Hard stop in case the block hangs.
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Receiver: random stalls, plus long hold-offs requested by the stimulus.
	initial begin
		csum.ready = 1'b0;
		hold_served = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left != 0) begin
				csum.ready <= 1'b0;
				hold_left = hold_left - 1;
			end else if (hold_served != hold_requests) begin
				csum.ready <= 1'b0;
				hold_left = HOLD_CYCLES;
				hold_served = hold_served + 1;
			end else begin
				csum.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	// Compare each checksum taken by the receiver with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && csum.valid === 1'b1 && csum.ready === 1'b1) begin
			if (checksum_expected.size() == 0) begin
				errors++;
				$display("%0t: checksum with none expected: expected none, actual %h",
					$time, csum.checksum);
			end else begin
				want_sum = checksum_expected.pop_front();
				if (csum.checksum !== want_sum) begin
					errors++;
					$display("%0t: checksum mismatch: expected %h, actual %h",
						$time, want_sum, csum.checksum);
				end
			end
		end
	end

	// Running sum of the segment; returns a checksum on the last data word.
	task automatic fold_in_word(input seg_word_t w, output logic has,
		output logic [HALF_W-1:0] sum);
		logic [SUM_W-1:0] s;
		has = 1'b0;
		sum = '0;
		if (w.action == ACT_START) begin
			seg_sum = SUM_W'(w.src[31:16]) + SUM_W'(w.src[15:0])
				+ SUM_W'(w.dst[31:16]) + SUM_W'(w.dst[15:0])
				+ SUM_W'(w.proto) + SUM_W'(w.seglen);
		end else begin
			seg_sum = seg_sum + SUM_W'(w.single ? (w.data & PAD_MASK) : w.data);
			if (w.last) begin
				// Fold the carries twice, then invert.
				s = SUM_W'(seg_sum[31:16]) + SUM_W'(seg_sum[15:0]);
				s = SUM_W'(s[31:16]) + SUM_W'(s[15:0]);
				sum = ~s[15:0];
				has = 1'b1;
				seg_sum = '0;
			end
		end
	endtask

	function automatic seg_word_t make_word(logic act, logic [ADDR_W-1:0] src,
		logic [ADDR_W-1:0] dst, logic [PROTO_W-1:0] proto, logic [HALF_W-1:0] seglen,
		logic [HALF_W-1:0] data, logic single, logic last_w, bit typed,
		logic [HALF_W-1:0] typed_sum);
		seg_word_t w;
		w.action = act;
		w.src = src;
		w.dst = dst;
		w.proto = proto;
		w.seglen = seglen;
		w.data = data;
		w.single = single;
		w.last = last_w;
		w.typed = typed;
		w.typed_sum = typed_sum;
		return w;
	endfunction

	// Random word; the fields that the action ignores are random as well.
	function automatic seg_word_t random_word(logic act, logic last_w, logic single);
		seg_word_t w;
		w = make_word(act, $urandom, $urandom, PROTO_W'($urandom), HALF_W'($urandom),
			HALF_W'($urandom), single, last_w, 1'b0, '0);
		if ($urandom_range(7) == 0)
			w.src = '1;
		if ($urandom_range(7) == 0)
			w.dst = '1;
		if ($urandom_range(3) == 0)
			w.data = '1;
		if (act == ACT_START) begin
			w.single = 1'($urandom_range(1));
			w.last = 1'($urandom_range(1));
		end
		return w;
	endfunction

	// Offer one word, wait for it to be taken, then record its checksum if any.
	task automatic drive_word(input seg_word_t w);
		logic              has;
		logic [HALF_W-1:0] sum;
		while ($urandom_range(99) < src_idle_pct) begin
			seg.valid <= 1'b0;
			@(posedge clk);
		end
		seg.valid <= 1'b1;
		seg.action <= w.action;
		seg.src_addr <= w.src;
		seg.dst_addr <= w.dst;
		seg.protocol <= w.proto;
		seg.seg_length <= w.seglen;
		seg.data_word <= w.data;
		seg.single_byte <= w.single;
		seg.last <= w.last;
		do
			@(posedge clk);
		while (seg.ready !== 1'b1);
		fold_in_word(w, has, sum);
		if (has)
			checksum_expected.push_back(w.typed ? w.typed_sum : sum);
		words_sent++;
	endtask

	// Mostly well-formed segments; the rest are stray words and broken segments.
	task automatic send_segment();
		int kind;
		int n;
		kind = $urandom_range(99);
		if (kind < 80) begin
			drive_word(random_word(ACT_START, 1'b0, 1'b0));
			n = ($urandom_range(9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 8);
			for (int i = 0; i < n; i++)
				drive_word(random_word(ACT_WORD, i == n - 1,
					(i == n - 1) ? ($urandom_range(2) == 0) : ($urandom_range(19) == 0)));
		end else if (kind < 90) begin
			n = $urandom_range(1, 3);
			for (int i = 0; i < n; i++)
				drive_word(random_word(ACT_WORD, 1'($urandom_range(1)),
					$urandom_range(3) == 0));
		end else begin
			drive_word(random_word(ACT_START, 1'b0, 1'b0));
			if ($urandom_range(1) == 0) begin
				drive_word(random_word(ACT_START, 1'b0, 1'b0));
			end else begin
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					drive_word(random_word(ACT_WORD, 1'b0, $urandom_range(3) == 0));
			end
		end
	endtask

	// Stop offering words until every checksum has come and the pipeline is empty.
	task automatic wait_drained();
		seg.valid <= 1'b0;
		while (checksum_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Random segments under one setting of idling on both sides.
	task automatic run_phase(input int idle_pct, input int stall_pct);
		int start_count;
		src_idle_pct = idle_pct;
		sink_stall_pct = stall_pct;
		start_count = words_sent;
		while (words_sent - start_count < PHASE_WORDS)
			send_segment();
		wait_drained();
	endtask

	// Main stimulus.
	initial begin
		arst_n = 1'b0;
		seg.valid = 1'b0;
		seg.action = ACT_START;
		seg.src_addr = '0;
		seg.dst_addr = '0;
		seg.protocol = '0;
		seg.seg_length = '0;
		seg.data_word = '0;
		seg.single_byte = 1'b0;
		seg.last = 1'b0;
		seg_sum = '0;
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_requests = 0;
		words_sent = 0;
		errors = 0;

		// Directed table: data word without a start, then extremes and special cases.
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h0000, 0, 1, 1, 16'hffff));
		directed_words.push_back(make_word(ACT_WORD, '1, '1, '1, '1, 16'hffff, 0, 1,
			1, 16'h0000));
		directed_words.push_back(make_word(ACT_START, 0, 0, 0, 0, 16'hffff, 1, 1, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h00ff, 1, 1, 1, 16'hffff));
		// All-ones pseudo header, padded byte mid-segment, carries to fold.
		directed_words.push_back(make_word(ACT_START, '1, '1, '1, '1, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'hffff, 1, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'hffff, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h1234, 0, 1, 0, 0));
		// A second start replaces the first; a segment that sums to all ones checks to zero.
		directed_words.push_back(make_word(ACT_START, '1, '1, '1, '1, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_START, 0, 0, 0, 0, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h1234, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'hedcb, 0, 1, 1, 16'h0000));
		// The sum is cleared after each last word.
		directed_words.push_back(make_word(ACT_WORD, '1, '1, '1, '1, 16'h8000, 0, 1,
			1, 16'h7fff));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'hffff, 1, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h00ff, 0, 1, 1, 16'h0000));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'habcd, 1, 1, 1, 16'h54ff));
		directed_words.push_back(make_word(ACT_START, 0, 0, 8'hff, 0, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h0000, 0, 1, 1, 16'hff00));
		directed_words.push_back(make_word(ACT_START, 32'h0a000001, 32'h0a000002, 8'd6,
			16'd20, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h1f90, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h0050, 0, 1, 0, 0));
		directed_words.push_back(make_word(ACT_START, 0, 0, 0, 16'hffff, 16'h0000, 0, 0, 0, 0));
		directed_words.push_back(make_word(ACT_WORD, 0, 0, 0, 0, 16'h0001, 0, 1, 0, 0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_words[i])
			drive_word(directed_words[i]);
		wait_drained();

		// Long receiver hold-off while short segments keep coming back to back.
		src_idle_pct = 0;
		sink_stall_pct = 0;
		hold_requests = hold_requests + 1;
		for (int i = 0; i < 12; i++) begin
			drive_word(random_word(ACT_START, 1'b0, 1'b0));
			drive_word(random_word(ACT_WORD, 1'b0, 1'b0));
			drive_word(random_word(ACT_WORD, 1'b1, 1'($urandom_range(1))));
		end
		wait_drained();

		run_phase(0, 0);
		run_phase(50, 0);
		run_phase(0, 50);
		run_phase(34, 34);

		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
